[rtl/lqf_pkg.sv]
// Package for the linked queue with free list: sizes, codes and request types.
// No dependencies; imported by lqf_pool and linked_queue_with_free_list.
package lqf_pkg;

  localparam int SLOTS     = 16;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
  } rsp_t;

  // link with its own null flag
  typedef struct packed {
    logic ok;
    idx_t idx;
  } link_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    link_t link;
  } link_wr_t;

  typedef struct packed {
    logic                 en;
    idx_t                 addr;
    logic [DATA_BITS-1:0] data;
  } data_wr_t;

  // power-up chain: slot i points at slot i+1, last slot is null
  function automatic link_t link_init(idx_t i);
    link_t l;
    l.ok  = (int'(i) + 1 < SLOTS);
    l.idx = l.ok ? idx_t'(int'(i) + 1) : '0;
    return l;
  endfunction

endpackage

[rtl/lqf_pool.sv]
// Slot pool: data and link memories, one write and one registered read each.
// Depends on lqf_pkg. Unwritten links read as the power-up free chain.
module lqf_pool (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  lqf_pkg::idx_t    rd_addr,
  input  lqf_pkg::link_wr_t link_wr,
  input  lqf_pkg::data_wr_t data_wr,
  output lqf_pkg::link_t   rd_link,
  output logic [lqf_pkg::DATA_BITS-1:0] rd_data
);
  import lqf_pkg::*;

  link_t                link_mem [SLOTS];
  logic [DATA_BITS-1:0] data_mem [SLOTS];
  logic [SLOTS-1:0]     written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (link_wr.en) begin
      written[link_wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (link_wr.en) begin
      link_mem[link_wr.addr] <= link_wr.link;
    end
    if (data_wr.en) begin
      data_mem[data_wr.addr] <= data_wr.data;
    end
    if (rd_en) begin
      rd_link <= written[rd_addr] ? link_mem[rd_addr] : link_init(rd_addr);
      rd_data <= data_mem[rd_addr];
    end
  end

endmodule

[rtl/linked_queue_with_free_list.sv]
// Linked FIFO queue in a slot pool with a free list; uses lqf_pkg, lqf_pool.
// A request accepted in S_IDLE has its response registered as S_EXEC ends; S_EXEC
// holds while a valid response is stalled. cmd_stall is high in S_EXEC, so a new request
// waits: the pool link read must return before the head, tail and free pointers update.
// Reset (rst, synchronous): queue empty, free list starts at slot 0, link valid
// bits cleared so links read as the in-order chain; no clearing pass.
module linked_queue_with_free_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  lqf_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lqf_pkg::rsp_t rsp
);
  import lqf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic op;
  logic signed [31:0] value;

  idx_t head_ptr, head_ptr_next;
  idx_t tail_ptr, tail_ptr_next;
  idx_t free_ptr, free_ptr_next;
  logic head_ok, head_ok_next;
  logic free_ok, free_ok_next;

  link_t                rd_link;
  logic [DATA_BITS-1:0] rd_data;
  link_wr_t             link_wr;
  data_wr_t             data_wr;
  rsp_t                 rsp_next;

  logic accept, exec_go;

  assign cmd_stall = (state == S_EXEC);
  assign accept    = cmd_valid & ~cmd_stall;
  assign exec_go   = (state == S_EXEC) & ~(rsp_valid & rsp_stall);

  lqf_pool u_pool (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr ((cmd.op == OP_DEQ) ? head_ptr : free_ptr),
    .link_wr (link_wr),
    .data_wr (data_wr),
    .rd_link (rd_link),
    .rd_data (rd_data)
  );

  // The tail's link is not written on enqueue and may be stale or null: the last entry is found by
  // comparing against tail_ptr, so an enqueue needs only one link write.
  always_comb begin
    head_ptr_next = head_ptr;
    tail_ptr_next = tail_ptr;
    free_ptr_next = free_ptr;
    head_ok_next  = head_ok;
    free_ok_next  = free_ok;
    link_wr       = '0;
    data_wr       = '0;
    rsp_next.status   = ST_DONE;
    rsp_next.data_out = '0;
    if (op == OP_ENQ) begin
      if (!free_ok) begin
        rsp_next.status = ST_FULL;
      end else begin
        free_ok_next  = rd_link.ok;
        free_ptr_next = rd_link.idx;
        data_wr.en    = exec_go;
        data_wr.addr  = free_ptr;
        data_wr.data  = DATA_BITS'($unsigned(value));
        if (head_ok) begin
          link_wr.en       = exec_go;
          link_wr.addr     = tail_ptr;
          link_wr.link.ok  = 1'b1;
          link_wr.link.idx = free_ptr;
        end else begin
          head_ptr_next = free_ptr;
          head_ok_next  = 1'b1;
        end
        tail_ptr_next = free_ptr;
      end
    end else begin
      if (!head_ok) begin
        rsp_next.status = ST_EMPTY;
      end else begin
        rsp_next.data_out = 32'(signed'(rd_data));
        if (head_ptr == tail_ptr) begin
          head_ok_next  = 1'b0;
          head_ptr_next = '0;
          tail_ptr_next = '0;
        end else begin
          head_ptr_next = rd_link.idx;
        end
        link_wr.en       = exec_go;
        link_wr.addr     = head_ptr;
        link_wr.link.ok  = free_ok;
        link_wr.link.idx = free_ptr;
        free_ptr_next    = head_ptr;
        free_ok_next     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_ptr  <= '0;
      tail_ptr  <= '0;
      free_ptr  <= '0;
      head_ok   <= 1'b0;
      free_ok   <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= S_EXEC;
      end else if (exec_go) begin
        state <= S_IDLE;
      end
      if (exec_go) begin
        head_ptr  <= head_ptr_next;
        tail_ptr  <= tail_ptr_next;
        free_ptr  <= free_ptr_next;
        head_ok   <= head_ok_next;
        free_ok   <= free_ok_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= cmd.op;
      value <= cmd.value;
    end
    if (exec_go) begin
      rsp <= rsp_next;
    end
  end

endmodule

[test/linked_queue_with_free_list_test.sv]
// Testbench for linked_queue_with_free_list: directed script, then random enqueue/dequeue
// traffic with idle bursts and one long response hold-off, checked against a slot-pool model.
// Depends on lqf_pkg and the linked_queue_with_free_list RTL.
`timescale 1ns / 100ps

module linked_queue_with_free_list_test;
  import lqf_pkg::*;

  localparam int WORD_W     = DATA_BITS;
  localparam int RAND_ITEMS = 1825;
  localparam int HOLD_LEN   = 64;

  typedef struct packed {
    logic        op;
    logic [31:0] value;
    logic        fixed;
    logic [1:0]  status;
    logic [31:0] data;
  } script_row_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  cmd_valid;
  logic  cmd_stall;
  cmd_t  cmd;
  logic  rsp_valid;
  logic  rsp_stall;
  rsp_t  rsp;

  // side info travelling with the request being offered
  logic  row_fixed;
  rsp_t  row_fixed_rsp;

  rsp_t  owed_rsp[$];
  int    mismatch_count = 0;
  bit    gaps_on = 1'b0;
  bit    quiet = 1'b0;
  bit    pressure_req = 1'b0;
  int    hold_left = 0;

  // pool model state
  logic signed [WORD_W-1:0] pool_word[SLOTS];
  link_t                    pool_next[SLOTS];
  link_t                    head_l;
  idx_t                     tail_idx;
  link_t                    free_l;

  script_row_t script [25] = '{
    '{OP_DEQ, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{OP_ENQ, 32'h7FFF_FFFF, 1'b1, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'h8000_0000, 1'b1, ST_DONE,  32'h0000_0000},
    '{OP_DEQ, 32'hFFFF_FFFF, 1'b1, ST_DONE,  32'h7FFF_FFFF},
    '{OP_DEQ, 32'h0000_0000, 1'b1, ST_DONE,  32'h8000_0000},
    // last entry gone: queue must read empty again
    '{OP_DEQ, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{OP_ENQ, 32'h0000_0000, 1'b1, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'hFFFF_FFFF, 1'b1, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'h5555_5555, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'hAAAA_AAAA, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'h0123_4567, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'h89AB_CDEF, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'h0000_0001, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'hFFFF_FFFE, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'h7FFF_FFFE, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'h8000_0001, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'h0F0F_0F0F, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'hF0F0_F0F0, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'h00FF_00FF, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'hFF00_FF00, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'h1357_9BDF, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_ENQ, 32'h2468_ACE0, 1'b0, ST_DONE,  32'h0000_0000},
    // all slots taken
    '{OP_ENQ, 32'h1234_5678, 1'b1, ST_FULL,  32'h0000_0000},
    '{OP_DEQ, 32'h0000_0000, 1'b1, ST_DONE,  32'h0000_0000},
    '{OP_DEQ, 32'h0000_0000, 1'b1, ST_DONE,  32'hFFFF_FFFF}
  };

  linked_queue_with_free_list DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one request to the pool model and returns the response it owes.
  function automatic rsp_t fifo_pool_step(cmd_t c);
    rsp_t                     r;
    idx_t                     s;
    logic signed [WORD_W-1:0] word;
    r = '0;
    r.status = ST_DONE;
    if (c.op == OP_ENQ) begin
      if (!free_l.ok) begin
        r.status = ST_FULL;
      end else begin
        s = free_l.idx;
        free_l = pool_next[s];
        pool_word[s] = WORD_W'(c.value);
        pool_next[s] = '0;
        if (!head_l.ok) begin
          head_l = '{1'b1, s};
        end else begin
          pool_next[tail_idx] = '{1'b1, s};
        end
        tail_idx = s;
      end
    end else begin
      if (!head_l.ok) begin
        r.status = ST_EMPTY;
      end else begin
        s = head_l.idx;
        word = pool_word[s];
        r.data_out = 32'(word);
        head_l = pool_next[s];
        if (!head_l.ok) begin
          head_l.idx = '0;
          tail_idx = '0;
        end
        // freed slot goes on top of the free list
        pool_next[s] = free_l;
        free_l = '{1'b1, s};
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offers one request from a falling edge and returns at the falling edge after acceptance.
  task automatic send_request(logic op, logic [31:0] value, logic fixed, rsp_t fixed_rsp);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      cmd <= {1'b1, pick_word()};
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= '{op, value};
    row_fixed <= fixed;
    row_fixed_rsp <= fixed_rsp;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // scoreboard: responses first (they belong to older requests), then new requests
  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_rsp.size() == 0) begin
          note_mismatch("unrequested response", 32'(rsp.status), 32'h0);
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.status !== want.status)
            note_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.data_out !== want.data_out)
            note_mismatch("data_out", rsp.data_out, want.data_out);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        want = fifo_pool_step(cmd);
        if (row_fixed)
          want = row_fixed_rsp;
        owed_rsp.push_back(want);
      end
    end
  end

  // response side back-pressure: short bursts, plus one long hold on request
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (pressure_req) begin
        pressure_req = 1'b0;
        hold_left = HOLD_LEN;
      end else if (!quiet && !rst && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 3);
      end
      rsp_stall <= (hold_left > 0);
    end
  end

  initial begin
    int   enq_pct;
    logic op;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    row_fixed = 1'b0;
    row_fixed_rsp = '0;
    for (int i = 0; i < SLOTS; i++) begin
      pool_next[i].ok  = (i + 1 < SLOTS);
      pool_next[i].idx = (i + 1 < SLOTS) ? idx_t'(i + 1) : '0;
    end
    head_l = '0;
    tail_idx = '0;
    free_l = '{1'b1, idx_t'(0)};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    gaps_on = 1'b1;
    foreach (script[i])
      send_request(script[i].op, script[i].value, script[i].fixed,
                   '{script[i].status, script[i].data});

    enq_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 15;
          1: enq_pct = 50;
          default: enq_pct = 85;
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      if (n == 700)
        pressure_req = 1'b1;
      // final stretch runs at full rate on both sides
      if (n >= RAND_ITEMS - 200) begin
        gaps_on = 1'b0;
        quiet = 1'b1;
      end
      op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
      send_request(op, pick_word(), 1'b0, '0);
    end

    cmd_valid <= 1'b0;
    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
